// ===== hw/rtl/bsc_pkg.sv =====
// bsc_pkg: shared field widths, item kinds, register indexes and the
// command/status structs between the safety checker controller and datapath.
// No dependencies.
package bsc_pkg;

   localparam int INDEX_WIDTH     = 4;
   localparam int AMOUNT_WIDTH    = 16;
   localparam int PID_WIDTH       = 5;
   localparam int PCOUNT_WIDTH    = 5;
   localparam int RCOUNT_WIDTH    = 4;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 5;
   localparam int REQ_DATA_WIDTH  = 40;
   localparam int RSP_DATA_WIDTH  = 8;

   // kind of an input beat
   typedef enum logic [1:0] {
      MODE_LOAD_TOTAL = 2'd0,
      MODE_LOAD_ENTRY = 2'd1,
      MODE_REQUEST    = 2'd2,
      MODE_CHECK      = 2'd3
   } mode_type;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESOURCE_COUNT = 1'b1;

   typedef struct packed {
      logic take;         // input beat accepted
      logic check_start;  // check beat accepted: clear scan state
      logic req_write;    // write back a captured request
      logic copy_step;    // copy one available count into the work set
      logic r_clear;      // restart resource walk
      logic test_issue;   // read one need entry for the fit test
      logic add_issue;    // read one allocation entry to return it
      logic next_proc;    // move scan to the next process
      logic grant;        // record the scanned process as finished
      logic emit_push;    // load next sequence result
      logic unsafe_push;  // load the unsafe result
   } ctrl_cmd_type;

   typedef struct packed {
      logic r_last;      // resource walk at its last type
      logic p_end;       // scan ran past the last process
      logic p_finished;  // scanned process already finished
      logic fits;        // need of scanned process fits in work set
      logic all_done;    // every process finished
      logic emit_last;   // next result is the final one
      logic rsp_free;    // output register can take a result
   } dp_status_type;

endpackage

// ===== hw/rtl/bsc_datapath.sv =====
// bsc_datapath: available counts, allocation/need memory, work set, scan
// counters, safe order store and the result register.
// Depends on bsc_pkg.
module bsc_datapath #(
   parameter int MAX_PROCESSES      = 16,
   parameter int MAX_RESOURCE_TYPES = 10,
   parameter int COUNT_WIDTH        = 16,
   localparam int CNTW = $clog2(MAX_PROCESSES + 1),
   localparam int RCW  = $clog2(MAX_RESOURCE_TYPES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bsc_pkg::ctrl_cmd_type             cmd,
   output bsc_pkg::dp_status_type            status,
   input  bsc_pkg::mode_type                 req_mode,
   input  logic [bsc_pkg::INDEX_WIDTH-1:0]   req_process_index,
   input  logic [bsc_pkg::INDEX_WIDTH-1:0]   req_resource_index,
   input  logic [bsc_pkg::AMOUNT_WIDTH-1:0]  req_amount,
   input  logic [bsc_pkg::AMOUNT_WIDTH-1:0]  req_max_claim,
   input  logic [CNTW-1:0]                   proc_limit,
   input  logic [RCW-1:0]                    res_limit,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [bsc_pkg::PID_WIDTH-1:0]     rsp_process_id,
   output logic                              rsp_safe,
   output logic                              rsp_granted,
   output logic                              rsp_last
);

   localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RW    = (MAX_RESOURCE_TYPES > 1) ? $clog2(MAX_RESOURCE_TYPES) : 1;
   localparam int PW1   = PW + 1;
   localparam int AW    = COUNT_WIDTH + 1;
   localparam int SW    = COUNT_WIDTH + 2;
   localparam int XW    = COUNT_WIDTH + 3;
   localparam int MW    = SW + AW;
   localparam int DEPTH = MAX_PROCESSES * (2 ** RW);

   // signed saturation from XW to SW bits
   function automatic logic [SW-1:0] sat_s(input logic [XW-1:0] x);
      logic [SW-1:0] y;
      if (x[XW-1] != x[XW-2]) begin
         y = {x[XW-1], {(SW-1){~x[XW-1]}}};
      end else begin
         y = x[SW-1:0];
      end
      return y;
   endfunction

   logic [SW-1:0]          avail_ff [MAX_RESOURCE_TYPES];
   logic [SW-1:0]          work_ff  [MAX_RESOURCE_TYPES];
   logic [MW-1:0]          entry_mem [DEPTH];
   logic [MW-1:0]          rd_data_ff;
   logic [PW-1:0]          order_ff [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] finished_ff, finished_in;

   logic [RW-1:0]          r_cnt_ff, r_cnt_in;
   logic [CNTW-1:0]        p_cnt_ff, p_cnt_in;
   logic [CNTW-1:0]        k_ff, k_in;
   logic [PW-1:0]          e_ff, e_in;
   logic                   fail_ff, fail_in;
   logic                   rd_test_ff, rd_add_ff;
   logic [RW-1:0]          rd_r_ff;
   logic                   request_made_ff, request_made_in;
   logic                   granted_ff;

   logic                   cap_ok_ff;
   logic [PW-1:0]          cap_p_ff;
   logic [RW-1:0]          cap_r_ff;
   logic [COUNT_WIDTH-1:0] cap_amt_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [bsc_pkg::PID_WIDTH-1:0] rsp_pid_ff, rsp_pid_in;
   logic                   rsp_safe_ff, rsp_safe_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   r_ok, p_ok;
   logic                   total_wr, entry_wr, req_wr, req_capture;
   logic [COUNT_WIDTH-1:0] amt_c, claim_c, amt_sel;
   logic [RW-1:0]          avail_idx;
   logic [SW-1:0]          avail_rd, avail_in;
   logic [XW-1:0]          avail_diff;
   logic                   avail_we;

   logic [AW-1:0]          rd_alloc;
   logic [SW-1:0]          rd_need;
   logic [AW:0]            alloc_sum;
   logic [AW-1:0]          alloc_new;
   logic [SW-1:0]          need_new, need_ld;
   logic [PW+RW-1:0]       wr_addr, rd_addr;
   logic [MW-1:0]          mem_wdata;
   logic                   mem_we;

   logic [SW-1:0]          work_rd, work_in;
   logic [RW-1:0]          work_idx;
   logic                   work_we;
   logic                   need_gt;
   logic [PW1-1:0]         pid_sum;
   logic                   emit_last;

   // item decode
   assign r_ok        = 32'(req_resource_index) < 32'(MAX_RESOURCE_TYPES);
   assign p_ok        = 32'(req_process_index) < 32'(MAX_PROCESSES);
   assign total_wr    = cmd.take && (req_mode == bsc_pkg::MODE_LOAD_TOTAL) && r_ok;
   assign entry_wr    = cmd.take && (req_mode == bsc_pkg::MODE_LOAD_ENTRY) && r_ok && p_ok;
   assign req_capture = cmd.take && (req_mode == bsc_pkg::MODE_REQUEST);
   assign req_wr      = cmd.req_write && cap_ok_ff;
   assign amt_c       = COUNT_WIDTH'(req_amount);
   assign claim_c     = COUNT_WIDTH'(req_max_claim);
   assign amt_sel     = cmd.req_write ? cap_amt_ff : amt_c;

   // available counts: one read index shared by loads, requests and the copy
   always_comb begin
      if (cmd.copy_step) begin
         avail_idx = r_cnt_ff;
      end else if (cmd.req_write) begin
         avail_idx = cap_r_ff;
      end else begin
         avail_idx = RW'(req_resource_index);
      end
   end

   assign avail_rd   = avail_ff[avail_idx];
   assign avail_diff = {avail_rd[SW-1], avail_rd} - {{(XW-COUNT_WIDTH){1'b0}}, amt_sel};
   assign avail_in   = total_wr ? {{(SW-COUNT_WIDTH){1'b0}}, amt_c} : sat_s(avail_diff);
   assign avail_we   = total_wr || entry_wr || req_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_RESOURCE_TYPES; i++) begin
            avail_ff[i] <= '0;
         end
      end else if (avail_we) begin
         avail_ff[avail_idx] <= avail_in;
      end
   end

   // allocation / need memory, word is {need, allocation}
   assign rd_alloc  = rd_data_ff[AW-1:0];
   assign rd_need   = rd_data_ff[MW-1:AW];
   assign alloc_sum = {1'b0, rd_alloc} + {{(AW+1-COUNT_WIDTH){1'b0}}, cap_amt_ff};
   assign alloc_new = alloc_sum[AW] ? {AW{1'b1}} : alloc_sum[AW-1:0];
   assign need_new  = sat_s({rd_need[SW-1], rd_need}
                            - {{(XW-COUNT_WIDTH){1'b0}}, cap_amt_ff});
   assign need_ld   = {2'b00, claim_c} - {2'b00, amt_c};
   assign mem_we    = entry_wr || req_wr;
   assign mem_wdata = cmd.req_write ? {need_new, alloc_new} : {need_ld, 1'b0, amt_c};
   assign wr_addr   = cmd.req_write ? {cap_p_ff, cap_r_ff}
                                    : {PW'(req_process_index), RW'(req_resource_index)};
   assign rd_addr   = req_capture ? {PW'(req_process_index), RW'(req_resource_index)}
                                  : {p_cnt_ff[PW-1:0], r_cnt_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // captured request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ok_ff <= 1'b0;
      end else if (req_capture) begin
         cap_ok_ff <= r_ok && p_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (req_capture) begin
         cap_p_ff   <= PW'(req_process_index);
         cap_r_ff   <= RW'(req_resource_index);
         cap_amt_ff <= amt_c;
      end
   end

   // work set: filled by the copy, raised by returned allocations
   assign work_rd  = work_ff[rd_r_ff];
   assign need_gt  = $signed(rd_need) > $signed(work_rd);
   assign work_in  = cmd.copy_step ? avail_rd
                                   : sat_s({work_rd[SW-1], work_rd} + {2'b00, rd_alloc});
   assign work_idx = cmd.copy_step ? r_cnt_ff : rd_r_ff;
   assign work_we  = cmd.copy_step || rd_add_ff;

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_ff[work_idx] <= work_in;
      end
      if (cmd.grant) begin
         order_ff[k_ff[PW-1:0]] <= p_cnt_ff[PW-1:0];
      end
      rd_r_ff <= r_cnt_ff;
   end

   // scan counters and flags
   always_comb begin
      r_cnt_in        = r_cnt_ff;
      p_cnt_in        = p_cnt_ff;
      k_in            = k_ff;
      e_in            = e_ff;
      fail_in         = fail_ff;
      finished_in     = finished_ff;
      request_made_in = request_made_ff;
      if (cmd.check_start || cmd.r_clear) begin
         r_cnt_in = '0;
      end else if (cmd.copy_step || cmd.test_issue || cmd.add_issue) begin
         r_cnt_in = RW'(r_cnt_ff + RW'(1));
      end
      if (cmd.check_start || cmd.grant) begin
         p_cnt_in = '0;
      end else if (cmd.next_proc) begin
         p_cnt_in = CNTW'(p_cnt_ff + CNTW'(1));
      end
      if (cmd.check_start) begin
         k_in = '0;
      end else if (cmd.grant) begin
         k_in = CNTW'(k_ff + CNTW'(1));
      end
      if (cmd.check_start) begin
         e_in = '0;
      end else if (cmd.emit_push) begin
         e_in = PW'(e_ff + PW'(1));
      end
      if (cmd.r_clear) begin
         fail_in = 1'b0;
      end else if (rd_test_ff && need_gt) begin
         fail_in = 1'b1;
      end
      if (cmd.check_start) begin
         finished_in = '0;
      end else if (cmd.grant) begin
         finished_in[p_cnt_ff[PW-1:0]] = 1'b1;
      end
      if (cmd.check_start) begin
         request_made_in = 1'b0;
      end else if (req_wr) begin
         request_made_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_cnt_ff        <= '0;
         p_cnt_ff        <= '0;
         k_ff            <= '0;
         e_ff            <= '0;
         fail_ff         <= 1'b0;
         finished_ff     <= '0;
         request_made_ff <= 1'b0;
         rd_test_ff      <= 1'b0;
         rd_add_ff       <= 1'b0;
      end else begin
         r_cnt_ff        <= r_cnt_in;
         p_cnt_ff        <= p_cnt_in;
         k_ff            <= k_in;
         e_ff            <= e_in;
         fail_ff         <= fail_in;
         finished_ff     <= finished_in;
         request_made_ff <= request_made_in;
         rd_test_ff      <= cmd.test_issue;
         rd_add_ff       <= cmd.add_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check_start) begin
         granted_ff <= request_made_ff;
      end
   end

   // result register
   assign emit_last = e_ff == PW'(proc_limit - CNTW'(1));
   assign pid_sum   = PW1'(order_ff[e_ff]) + PW1'(1);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_pid_in     = rsp_pid_ff;
      rsp_safe_in    = rsp_safe_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.emit_push) begin
         rsp_valid_in   = 1'b1;
         rsp_pid_in     = bsc_pkg::PID_WIDTH'(pid_sum);
         rsp_safe_in    = 1'b1;
         rsp_granted_in = granted_ff;
         rsp_last_in    = emit_last;
      end else if (cmd.unsafe_push) begin
         rsp_valid_in   = 1'b1;
         rsp_pid_in     = '0;
         rsp_safe_in    = 1'b0;
         rsp_granted_in = 1'b0;
         rsp_last_in    = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pid_ff     <= rsp_pid_in;
      rsp_safe_ff    <= rsp_safe_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_process_id = rsp_pid_ff;
   assign rsp_safe       = rsp_safe_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_last       = rsp_last_ff;

   // status
   assign status.r_last     = r_cnt_ff == RW'(res_limit - RCW'(1));
   assign status.p_end      = p_cnt_ff == proc_limit;
   assign status.p_finished = finished_ff[p_cnt_ff[PW-1:0]];
   assign status.fits       = !(fail_ff || (rd_test_ff && need_gt));
   assign status.all_done   = k_ff == proc_limit;
   assign status.emit_last  = emit_last;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   // a grant picks an unfinished process while slots remain in the order
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> !finished_ff[p_cnt_ff[PW-1:0]] && (k_ff != proc_limit))
      else $error("grant of a finished process or past the process count");

   // fit test and allocation return never share the read pipeline
   assert property (@(posedge clock) disable iff (reset)
      !(rd_test_ff && rd_add_ff))
      else $error("test and add reads in flight together");

   // a pushed result shows on the port in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_push || cmd.unsafe_push) |=> rsp_tvalid)
      else $error("pushed result not presented");

endmodule

// ===== hw/rtl/bsc_controller.sv =====
// bsc_controller: state machine that sequences item handling, the safety
// scan and result emission; drives datapath commands from its status.
// Depends on bsc_pkg.
module bsc_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  bsc_pkg::mode_type      req_mode,
   output logic                   req_tready,
   input  bsc_pkg::dp_status_type status,
   output bsc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b00_0000_0001,
      ST_REQ_UPDATE = 10'b00_0000_0010,
      ST_COPY       = 10'b00_0000_0100,
      ST_SCAN_HEAD  = 10'b00_0000_1000,
      ST_TEST       = 10'b00_0001_0000,
      ST_TEST_WAIT  = 10'b00_0010_0000,
      ST_ADD        = 10'b00_0100_0000,
      ST_ADD_WAIT   = 10'b00_1000_0000,
      ST_EMIT       = 10'b01_0000_0000,
      ST_UNSAFE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_mode == bsc_pkg::MODE_CHECK) begin
                  cmd.check_start = 1'b1;
                  state_in        = ST_COPY;
               end else if (req_mode == bsc_pkg::MODE_REQUEST) begin
                  state_in = ST_REQ_UPDATE;
               end
            end
         end
         ST_REQ_UPDATE: begin
            cmd.req_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.r_last) begin
               state_in = ST_SCAN_HEAD;
            end
         end
         ST_SCAN_HEAD: begin
            if (status.all_done) begin
               state_in = ST_EMIT;
            end else if (status.p_end) begin
               state_in = ST_UNSAFE;
            end else if (status.p_finished) begin
               cmd.next_proc = 1'b1;
            end else begin
               cmd.r_clear = 1'b1;
               state_in    = ST_TEST;
            end
         end
         ST_TEST: begin
            cmd.test_issue = 1'b1;
            if (status.r_last) begin
               state_in = ST_TEST_WAIT;
            end
         end
         ST_TEST_WAIT: begin
            if (status.fits) begin
               cmd.r_clear = 1'b1;
               state_in    = ST_ADD;
            end else begin
               cmd.next_proc = 1'b1;
               state_in      = ST_SCAN_HEAD;
            end
         end
         ST_ADD: begin
            cmd.add_issue = 1'b1;
            if (status.r_last) begin
               state_in = ST_ADD_WAIT;
            end
         end
         ST_ADD_WAIT: begin
            cmd.grant = 1'b1;
            state_in  = ST_SCAN_HEAD;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit_push = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_UNSAFE: begin
            if (status.rsp_free) begin
               cmd.unsafe_push = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a check beat closes the input until its last result is in the output register
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_mode == bsc_pkg::MODE_CHECK)) |=> !req_tready)
      else $error("input open right after a check beat");

   // results are only pushed into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_push || cmd.unsafe_push) |-> status.rsp_free)
      else $error("result pushed over a waiting result");

   // a grant always follows a complete allocation return walk
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> $past(cmd.add_issue))
      else $error("grant without allocation return");

endmodule

// ===== hw/rtl/bankers_safety_checker.sv =====
// bankers_safety_checker: top level of the deadlock-avoidance safety checker;
// holds the count registers and joins bsc_controller and bsc_datapath.
// Depends on bsc_pkg, bsc_controller, bsc_datapath.
//
// Input beats load resource totals (kind 0), load one process's allocation and
// maximum claim for one resource type (kind 1), apply one resource type of a
// request without validation (kind 2) or start a safety check (kind 3). Kind 0
// and kind 1 beats are taken in the idle state, which they do not leave, so
// loads stream at full rate; a request reads its entry when it is taken and
// then adjusts and writes it back in the update state, with the input closed
// meanwhile. A check first copies the available counts into a work set, then
// scans processes from index 0: a finished process is skipped, an unfinished
// one gets a fit test over every resource type, and a grant returns its
// allocation to the work set, after which the scan restarts at process 0. The
// fit test and the allocation return walk the memory one entry per cycle. The
// input stays closed from a check beat until its last result is in the output
// register. A safe state streams the whole sequence, one beat per process with
// tlast on the final one; an unsafe state gives one beat with process id 0.
// Count registers read 0 as 1 and clamp above the configured maxima; the user
// must write them only while the block is idle, as the block itself does not
// enforce this.
module bankers_safety_checker #(
   parameter int MAX_PROCESSES      = 16,
   parameter int MAX_RESOURCE_TYPES = 10,
   parameter int COUNT_WIDTH        = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // process_index[3:0], resource_index[7:4], amount[23:8], max_claim[39:24]
   input  logic [bsc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // mode[1:0]
   input  logic [1:0]                           req_tuser,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // process_id[4:0], safe[5], request_granted[6], zero pad[7]
   output logic [bsc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   // register write port
   input  logic                                 csr_we,
   input  logic [bsc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int CNTW = $clog2(MAX_PROCESSES + 1);
   localparam int RCW  = $clog2(MAX_RESOURCE_TYPES + 1);

   logic [bsc_pkg::PCOUNT_WIDTH-1:0] pcount_ff;
   logic [bsc_pkg::RCOUNT_WIDTH-1:0] rcount_ff;
   logic [CNTW-1:0]                  proc_limit;
   logic [RCW-1:0]                   res_limit;

   bsc_pkg::mode_type      req_mode;
   bsc_pkg::ctrl_cmd_type  cmd;
   bsc_pkg::dp_status_type status;

   logic [bsc_pkg::PID_WIDTH-1:0] rsp_process_id;
   logic                          rsp_safe;
   logic                          rsp_granted;

   // count registers, both reset to one
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= bsc_pkg::PCOUNT_WIDTH'(1);
         rcount_ff <= bsc_pkg::RCOUNT_WIDTH'(1);
      end else if (csr_we) begin
         if (csr_index == bsc_pkg::CSR_PROCESS_COUNT) begin
            pcount_ff <= csr_data[bsc_pkg::PCOUNT_WIDTH-1:0];
         end
         if (csr_index == bsc_pkg::CSR_RESOURCE_COUNT) begin
            rcount_ff <= csr_data[bsc_pkg::RCOUNT_WIDTH-1:0];
         end
      end
   end

   // zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (pcount_ff == '0) begin
         proc_limit = CNTW'(1);
      end else if (32'(pcount_ff) > 32'(MAX_PROCESSES)) begin
         proc_limit = CNTW'(MAX_PROCESSES);
      end else begin
         proc_limit = CNTW'(pcount_ff);
      end
      if (rcount_ff == '0) begin
         res_limit = RCW'(1);
      end else if (32'(rcount_ff) > 32'(MAX_RESOURCE_TYPES)) begin
         res_limit = RCW'(MAX_RESOURCE_TYPES);
      end else begin
         res_limit = RCW'(rcount_ff);
      end
   end

   assign req_mode = bsc_pkg::mode_type'(req_tuser);

   bsc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_mode),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bsc_datapath #(
      .MAX_PROCESSES      (MAX_PROCESSES),
      .MAX_RESOURCE_TYPES (MAX_RESOURCE_TYPES),
      .COUNT_WIDTH        (COUNT_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_process_index  (req_tdata[3:0]),
      .req_resource_index (req_tdata[7:4]),
      .req_amount         (req_tdata[23:8]),
      .req_max_claim      (req_tdata[39:24]),
      .proc_limit         (proc_limit),
      .res_limit          (res_limit),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_process_id     (rsp_process_id),
      .rsp_safe           (rsp_safe),
      .rsp_granted        (rsp_granted),
      .rsp_last           (rsp_tlast)
   );

   // result beat packing
   assign rsp_tdata = {1'b0, rsp_granted, rsp_safe, rsp_process_id};

endmodule

// ===== tb/bankers_safety_checker_tb.sv =====
// bankers_safety_checker_tb: self-checking testbench for the banker's safety checker,
// driving loads, requests and checks and comparing every result beat with its own model.
// Depends on bsc_pkg and bankers_safety_checker.
module bankers_safety_checker_tb;
   import bsc_pkg::*;

   localparam int NUM_PROCS     = 16;
   localparam int NUM_RES       = 10;
   localparam int COUNT_W       = 16;
   localparam int RANDOM_ITEMS  = 110;
   localparam int LONG_HOLD     = 400;        // receiver hold-off for the pressure test
   localparam int SETTLE_CYCLES = 8;          // settle time for a request to write back
   localparam int DRAIN_CYCLES  = 2000;       // longer than a full-size check
   localparam int CYCLE_LIMIT   = 4000000;

   // signed range of available and need counts, unsigned range of allocations
   localparam longint COUNT_HI = (longint'(1) << (COUNT_W + 1)) - 1;
   localparam longint COUNT_LO = -COUNT_HI - 1;

   // one result beat as the checker expects it
   typedef struct packed {
      logic [PID_WIDTH-1:0] process_id;
      logic                 safe;
      logic                 granted;
      logic                 last;
   } outcome_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata;
   logic [1:0]                  req_tuser;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        rsp_tlast;
   logic                        csr_we;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_data;

   // model of the block's stored counts and registers
   logic signed [COUNT_W+1:0] avail_model [NUM_RES];
   logic [COUNT_W:0]          alloc_model [NUM_PROCS][NUM_RES];
   logic signed [COUNT_W+1:0] need_model  [NUM_PROCS][NUM_RES];
   bit                        request_pending;
   logic [PCOUNT_WIDTH-1:0]   pcount_reg;
   logic [RCOUNT_WIDTH-1:0]   rcount_reg;

   outcome_type sequence_due [$];    // result beats still to arrive, oldest first
   int          mismatches;
   int          items_accepted;      // beats that the block acts on
   int          cycle_count;
   bit          tx_idling;
   bit          rx_idling;
   int          hold_requests;
   int          holds_started;
   int          stall_left;

   bankers_safety_checker #(
      .MAX_PROCESSES     (NUM_PROCS),
      .MAX_RESOURCE_TYPES(NUM_RES),
      .COUNT_WIDTH       (COUNT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic logic signed [COUNT_W+1:0] sat_count(input longint v);
      if (v > COUNT_HI) return COUNT_HI[COUNT_W+1:0];
      if (v < COUNT_LO) return COUNT_LO[COUNT_W+1:0];
      return v[COUNT_W+1:0];
   endfunction

   function automatic logic [COUNT_W:0] sat_alloc(input longint v);
      if (v > COUNT_HI) return COUNT_HI[COUNT_W:0];
      if (v < 0) return '0;
      return v[COUNT_W:0];
   endfunction

   // register value 0 behaves as 1, anything above the maximum as the maximum
   function automatic int clamp_count(input int raw, input int top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   // append one expected beat behind those still due
   function automatic void queue_beat(input outcome_type item);
      sequence_due = {sequence_due, item};
   endfunction

   // the safety scan: lowest unfinished process that fits, rescan from 0 after each grant
   function automatic void compute_safe_sequence();
      int          np;
      int          nr;
      int          done_count;
      longint      work [NUM_RES];
      bit          finished_now [NUM_PROCS];
      int          order [NUM_PROCS];
      bit          found;
      bit          fits;
      bit          stuck;
      bit          granted;
      outcome_type beat;
      np = clamp_count(pcount_reg, NUM_PROCS);
      nr = clamp_count(rcount_reg, NUM_RES);
      granted = request_pending;
      request_pending = 1'b0;
      done_count = 0;
      stuck = 1'b0;
      foreach (finished_now[i]) finished_now[i] = 1'b0;
      for (int r = 0; r < NUM_RES; r++) work[r] = avail_model[r];
      while (done_count < np && !stuck) begin
         found = 1'b0;
         for (int p = 0; p < np && !found; p++) begin
            if (!finished_now[p]) begin
               fits = 1'b1;
               for (int r = 0; r < nr; r++)
                  if (longint'(need_model[p][r]) > work[r]) fits = 1'b0;
               if (fits) begin
                  found = 1'b1;
                  finished_now[p] = 1'b1;
                  for (int r = 0; r < nr; r++)
                     work[r] = sat_count(work[r] + longint'(alloc_model[p][r]));
                  order[done_count] = p;
                  done_count++;
               end
            end
         end
         if (!found) stuck = 1'b1;
      end
      if (stuck) begin
         // unsafe: a single beat, no part of the sequence
         beat.process_id = '0;
         beat.safe       = 1'b0;
         beat.granted    = 1'b0;
         beat.last       = 1'b1;
         queue_beat(beat);
      end else begin
         for (int k = 0; k < np; k++) begin
            beat.process_id = PID_WIDTH'(order[k] + 1);
            beat.safe       = 1'b1;
            beat.granted    = granted;
            beat.last       = (k == np - 1);
            queue_beat(beat);
         end
      end
   endfunction

   function automatic void apply_item(input mode_type kind, input logic [3:0] proc,
                                      input logic [3:0] res, input logic [15:0] amt,
                                      input logic [15:0] claim);
      if (kind == MODE_CHECK) begin
         compute_safe_sequence();
      end else if (res < NUM_RES) begin
         case (kind)
            MODE_LOAD_TOTAL: begin
               avail_model[res] = sat_count(longint'(amt));
            end
            MODE_LOAD_ENTRY: begin
               // reloading does not give the old allocation back
               alloc_model[proc][res] = sat_alloc(longint'(amt));
               need_model[proc][res]  = sat_count(longint'(claim) - longint'(amt));
               avail_model[res]       = sat_count(longint'(avail_model[res]) - longint'(amt));
            end
            default: begin
               // request, applied without validation
               alloc_model[proc][res] = sat_alloc(longint'(alloc_model[proc][res])
                                                  + longint'(amt));
               need_model[proc][res]  = sat_count(longint'(need_model[proc][res])
                                                  - longint'(amt));
               avail_model[res]       = sat_count(longint'(avail_model[res]) - longint'(amt));
               request_pending = 1'b1;
            end
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report(input string field, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d, cycle %0d",
               field, got, want, cycle_count);
      mismatches++;
   endtask

   // every accepted result beat against the oldest expectation
   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sequence_due.size() == 0) begin
            report("unexpected result beat", rsp_tdata, -1);
         end else begin
            want = sequence_due.pop_front();
            if (rsp_tdata[4:0] !== want.process_id)
               report("process_id", rsp_tdata[4:0], want.process_id);
            if (rsp_tdata[5] !== want.safe) report("safe", rsp_tdata[5], want.safe);
            if (rsp_tdata[6] !== want.granted)
               report("request_granted", rsp_tdata[6], want.granted);
            if (rsp_tdata[7] !== 1'b0) report("pad bit", rsp_tdata[7], 0);
            if (rsp_tlast !== want.last) report("tlast", rsp_tlast, want.last);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bankers_safety_checker verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // mostly no gap or a short one, now and then a long one
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, plus a long counted hold-off on request
   always @(negedge clock) begin
      if (hold_requests != holds_started) begin
         holds_started <= hold_requests;
         stall_left    <= LONG_HOLD - 1;
         rsp_tready    <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
         stall_left <= idle_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one input beat; tvalid stays high into the next beat when there is no gap
   task automatic send_item(input mode_type kind, input logic [3:0] proc,
                            input logic [3:0] res, input logic [15:0] amt,
                            input logic [15:0] claim);
      int gap;
      gap = tx_idling ? idle_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {claim, amt, res, proc};
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_item(kind, proc, res, amt, claim);
      if (kind == MODE_CHECK || res < NUM_RES) items_accepted++;
   endtask

   task automatic send_check();
      send_item(MODE_CHECK, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // block idle: all results in, plus time for a request to write back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sequence_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      wait_idle();
      csr_index <= idx;
      csr_data  <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PROCESS_COUNT) pcount_reg = value;
      else rcount_reg = value[RCOUNT_WIDTH-1:0];
   endtask

   task automatic set_counts(input int np_raw, input int nr_raw);
      write_csr(CSR_PROCESS_COUNT, CSR_DATA_WIDTH'(np_raw));
      write_csr(CSR_RESOURCE_COUNT, CSR_DATA_WIDTH'(nr_raw));
   endtask

   // totals first, then every entry of the np x nr region; roomy leaves enough
   // spare in available for any single need, so the state is safe while no total is capped
   task automatic load_state(input int np, input int nr, input int span, input bit roomy);
      logic [15:0] alloc_pick [NUM_PROCS][NUM_RES];
      logic [15:0] need_pick  [NUM_PROCS][NUM_RES];
      longint      sum;
      for (int r = 0; r < nr; r++) begin
         sum = 0;
         for (int p = 0; p < np; p++) begin
            alloc_pick[p][r] = 16'($urandom_range(0, span / 4));
            need_pick[p][r]  = 16'($urandom_range(0, span / 4));
            sum += alloc_pick[p][r];
         end
         sum += roomy ? $urandom_range(span / 4, span / 2) : $urandom_range(0, span / 2);
         if (sum > 65535) sum = 65535;
         send_item(MODE_LOAD_TOTAL, 4'($urandom), 4'(r), sum[15:0], 16'($urandom));
      end
      for (int p = 0; p < np; p++)
         for (int r = 0; r < nr; r++)
            send_item(MODE_LOAD_ENTRY, 4'(p), 4'(r), alloc_pick[p][r],
                      alloc_pick[p][r] + need_pick[p][r]);
   endtask

   // ---------------------------------------------------------------- tests

   // two processes, two types: a plain sequence, a granted request, ignored beats
   task automatic test_basic_sequence();
      set_counts(2, 2);
      send_item(MODE_LOAD_TOTAL, 4'd0, 4'd0, 16'd10, 16'd0);
      send_item(MODE_LOAD_TOTAL, 4'd0, 4'd1, 16'd5, 16'd0);
      send_item(MODE_LOAD_ENTRY, 4'd0, 4'd0, 16'd4, 16'd9);
      send_item(MODE_LOAD_ENTRY, 4'd0, 4'd1, 16'd1, 16'd3);
      send_item(MODE_LOAD_ENTRY, 4'd1, 4'd0, 16'd2, 16'd4);
      send_item(MODE_LOAD_ENTRY, 4'd1, 4'd1, 16'd2, 16'd2);
      send_check();
      send_item(MODE_REQUEST, 4'd0, 4'd0, 16'd1, 16'd0);
      send_check();
      // resource index past the last type: ignored in both loading modes and in requests
      send_item(MODE_LOAD_TOTAL, 4'd0, 4'd15, 16'hFFFF, 16'hFFFF);
      send_item(MODE_LOAD_ENTRY, 4'd15, 4'd12, 16'h1234, 16'hFFFF);
      send_item(MODE_REQUEST, 4'd1, 4'd10, 16'hFFFF, 16'h0);
      send_check();
   endtask

   // full-range amounts drive available, need and allocation into saturation
   task automatic test_saturation();
      set_counts(1, 1);
      send_item(MODE_LOAD_TOTAL, 4'd0, 4'd0, 16'd0, 16'd0);
      send_item(MODE_LOAD_ENTRY, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF);
      send_item(MODE_LOAD_ENTRY, 4'd0, 4'd0, 16'hFFFF, 16'd0);
      send_item(MODE_LOAD_ENTRY, 4'd0, 4'd0, 16'hFFFF, 16'd0);
      send_check();
      send_item(MODE_REQUEST, 4'd0, 4'd0, 16'hFFFF, 16'd0);
      send_item(MODE_REQUEST, 4'd0, 4'd0, 16'hFFFF, 16'd0);
      send_check();
   endtask

   // zero in both count registers acts as one
   task automatic test_count_clamping();
      set_counts(0, 0);
      send_check();
   endtask

   // every process and type; counts above the maxima, then exactly at them
   task automatic test_full_size();
      set_counts(31, 15);
      load_state(NUM_PROCS, NUM_RES, 63, 1'b1);
      send_check();
      set_counts(NUM_PROCS, NUM_RES);
      send_check();
      repeat (4)
         send_item(MODE_REQUEST, 4'($urandom_range(0, NUM_PROCS - 1)),
                   4'($urandom_range(0, NUM_RES - 1)), 16'($urandom_range(0, 7)), 16'd0);
      send_check();
   endtask

   // receiver holds off long while the sender keeps offering beats behind a check
   task automatic test_output_hold_off();
      set_counts(4, 2);
      load_state(4, 2, 15, 1'b1);
      tx_idling = 1'b0;
      hold_requests++;
      send_check();
      repeat (3)
         send_item(MODE_REQUEST, 4'($urandom_range(0, 3)), 4'($urandom_range(0, 1)),
                   16'($urandom_range(0, 2)), 16'($urandom));
      send_check();
      send_check();
      tx_idling = 1'b1;
   endtask

   // random scenarios: well-formed loads, requests and checks with some noise
   task automatic test_random_scenarios();
      int first_count;
      int np_raw;
      int nr_raw;
      int np;
      int nr;
      int span;
      int p;
      int r;
      first_count = items_accepted;
      while (items_accepted - first_count < RANDOM_ITEMS) begin
         np_raw = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(0, 31);
         nr_raw = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 15);
         set_counts(np_raw, nr_raw);
         np = clamp_count(np_raw, NUM_PROCS);
         nr = clamp_count(nr_raw, NUM_RES);
         case ($urandom_range(0, 3))
            0: span = 15;
            1: span = 255;
            2: span = 4095;
            default: span = 65535;
         endcase
         tx_idling = ($urandom_range(0, 3) != 0);
         rx_idling = ($urandom_range(0, 3) != 0);
         load_state(np, nr, span, 1'($urandom));
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 4)) begin
               p = $urandom_range(0, np - 1);
               r = $urandom_range(0, nr - 1);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4:
                     send_item(MODE_REQUEST, 4'(p), 4'(r),
                               16'($urandom_range(0, span / 8)), 16'($urandom));
                  5:
                     send_item(MODE_REQUEST, 4'(p), 4'(r), 16'($urandom), 16'($urandom));
                  6:
                     send_item(MODE_LOAD_TOTAL, 4'($urandom), 4'(r),
                               16'($urandom_range(0, span)), 16'($urandom));
                  7:
                     send_item(MODE_LOAD_ENTRY, 4'($urandom), 4'($urandom_range(0, NUM_RES - 1)),
                               16'($urandom), 16'($urandom));
                  8:
                     // ignored beat: type index past the last one
                     send_item(mode_type'($urandom_range(0, 2)), 4'($urandom),
                               4'($urandom_range(NUM_RES, 15)), 16'($urandom), 16'($urandom));
                  default:
                     send_item(MODE_LOAD_ENTRY, 4'(p), 4'(r),
                               16'($urandom_range(0, span / 4)), 16'($urandom_range(0, span / 2)));
               endcase
            end
            send_check();
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      rsp_tready      = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      mismatches      = 0;
      items_accepted  = 0;
      cycle_count     = 0;
      tx_idling       = 1'b1;
      rx_idling       = 1'b1;
      hold_requests   = 0;
      holds_started   = 0;
      stall_left      = 0;
      request_pending = 1'b0;
      pcount_reg      = 1;
      rcount_reg      = 1;
      foreach (avail_model[r]) avail_model[r] = '0;
      foreach (alloc_model[p, r]) alloc_model[p][r] = '0;
      foreach (need_model[p, r]) need_model[p][r] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_sequence();
      test_saturation();
      test_count_clamping();
      test_full_size();
      test_output_hold_off();
      test_random_scenarios();

      // drain: every expected beat in, then room for anything stray
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sequence_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("bankers_safety_checker verification clean");
      end else begin
         $display("bankers_safety_checker verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_datapath.sv
hw/rtl/bsc_controller.sv
hw/rtl/bankers_safety_checker.sv
tb/bankers_safety_checker_tb.sv
